FILE: src/dh_joint_transform_defines.svh
// assertion macros used by the port-level checker of the joint transform
`ifndef DH_JOINT_TRANSFORM_DEFINES_SVH
`define DH_JOINT_TRANSFORM_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define DHJT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with a fixed delay in clock cycles
`define DHJT_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

FILE: src/dhjt_pkg.sv
// shared constants, types and helper functions of the joint transform
`default_nettype none

package dhjt_pkg;

	// Q16.16 angle constants
	localparam int TWO_PI_Q16  = 411775;
	localparam int PI_Q16      = 205887;
	localparam int HALF_PI_Q16 = 102944;

	// cordic start vector, x = gain in Q2.30
	localparam int CORDIC_GAIN_Q30 = 652032874;

	localparam int unsigned CORDIC_STAGES_DEF = 16;

	// cycles of the angle reduction pipe
	localparam int unsigned RED_LAT = 7;
	// request to result, not counting the cordic cells
	localparam int unsigned FIXED_LAT = 12;

	typedef enum logic [2:0] {
		REG_JOINT_TYPE,
		REG_LOWER_LIMIT,
		REG_UPPER_LIMIT,
		REG_ANGLE_OFFSET,
		REG_DISTANCE_OFFSET,
		REG_LINK_LENGTH,
		REG_TWIST_ANGLE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		JOINT_REVOLUTE,
		JOINT_PRISMATIC,
		JOINT_FIXED
	} joint_type_t;

	// one rotation in flight: vector in Q2.30, residual angle, quadrant fold flag
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [32:0] z;
		logic               neg;
	} lane_t;

	// request payload that rides along the rotation
	typedef struct packed {
		logic signed [31:0] clamped;
		logic signed [31:0] d_sum;
	} side_t;

	// arctangent of 2^-i in Q2.30
	function automatic logic signed [32:0] atan_q30(input int unsigned idx);
		logic signed [32:0] val;
		case (idx)
			0:  val = 33'sd843314857;
			1:  val = 33'sd497837829;
			2:  val = 33'sd263043837;
			3:  val = 33'sd133525159;
			4:  val = 33'sd67021687;
			5:  val = 33'sd33543516;
			6:  val = 33'sd16775851;
			7:  val = 33'sd8388437;
			8:  val = 33'sd4194283;
			9:  val = 33'sd2097149;
			10: val = 33'sd1048576;
			11: val = 33'sd524288;
			12: val = 33'sd262144;
			13: val = 33'sd131072;
			14: val = 33'sd65536;
			15: val = 33'sd32768;
			16: val = 33'sd16384;
			17: val = 33'sd8192;
			18: val = 33'sd4096;
			19: val = 33'sd2048;
			20: val = 33'sd1024;
			21: val = 33'sd512;
			22: val = 33'sd256;
			23: val = 33'sd128;
			24: val = 33'sd64;
			25: val = 33'sd32;
			26: val = 33'sd16;
			27: val = 33'sd8;
			28: val = 33'sd4;
			29: val = 33'sd2;
			default: val = 33'sd0;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

FILE: src/dhjt_reduce.sv
// reduces a Q16.16 angle modulo 2*pi and folds it into the cordic start lane
`default_nettype none

module dhjt_reduce (
	input  wire logic               clk,
	input  wire logic signed [31:0] angle,
	output dhjt_pkg::lane_t         lane
);
	import dhjt_pkg::*;

	// offset by a multiple of 2*pi so the dividend is never negative
	localparam longint unsigned WRAP_COUNT =
		(64'd2147483648 + 64'(TWO_PI_Q16) - 64'd1) / 64'(TWO_PI_Q16);
	localparam logic [33:0] WRAP_OFS = 34'(WRAP_COUNT * 64'(TWO_PI_Q16));
	// floor(2^36 / 2*pi), quotient estimate is at most one short
	localparam logic [17:0] RECIP = 18'((64'd1 << 36) / 64'(TWO_PI_Q16));

	logic        [32:0] t_s1, t_s2, t_s3;
	logic        [36:0] prod_s2;
	logic        [32:0] qc_s3;
	logic        [19:0] r0_s4;
	logic        [18:0] r_s5;
	logic signed [18:0] sr_s6;
	lane_t              lane_s7;

	logic        [33:0] wrap_sum;
	logic        [14:0] quo;
	logic        [32:0] diff;
	logic signed [19:0] r_wide;
	logic signed [18:0] fold;
	logic               fold_neg;

	always_comb begin
		wrap_sum = 34'(angle) + WRAP_OFS;
		quo      = prod_s2[36:22];
		diff     = t_s3 - qc_s3;
		r_wide   = $signed({1'b0, r_s5}) - 20'(TWO_PI_Q16);
	end

	// fold into [-pi/2, pi/2], sine and cosine flip sign afterwards
	always_comb begin
		fold     = sr_s6;
		fold_neg = 1'b0;
		if (sr_s6 > 19'(HALF_PI_Q16)) begin
			fold     = sr_s6 - 19'(PI_Q16);
			fold_neg = 1'b1;
		end else if (sr_s6 < -19'(HALF_PI_Q16)) begin
			fold     = sr_s6 + 19'(PI_Q16);
			fold_neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= wrap_sum[32:0];
		prod_s2 <= {18'd0, t_s1[32:14]} * 37'(RECIP);
		t_s2    <= t_s1;
		qc_s3   <= {18'd0, quo} * 33'(TWO_PI_Q16);
		t_s3    <= t_s2;
		r0_s4   <= diff[19:0];
		if (r0_s4 >= 20'(TWO_PI_Q16)) begin
			r_s5 <= 19'(r0_s4 - 20'(TWO_PI_Q16));
		end else begin
			r_s5 <= r0_s4[18:0];
		end
		if (r_s5 > 19'(PI_Q16)) begin
			sr_s6 <= r_wide[18:0];
		end else begin
			sr_s6 <= $signed(r_s5);
		end
		lane_s7.x   <= 32'(CORDIC_GAIN_Q30);
		lane_s7.y   <= '0;
		lane_s7.z   <= 33'(fold) <<< 14;
		lane_s7.neg <= fold_neg;
	end

	assign lane = lane_s7;

endmodule

`default_nettype wire

FILE: src/dhjt_cordic_cell.sv
// one cordic micro-rotation for the joint angle and the twist angle
`default_nettype none

module dhjt_cordic_cell #(
	parameter int unsigned STAGE = 0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  dhjt_pkg::lane_t  in_theta,
	input  dhjt_pkg::lane_t  in_alpha,
	input  dhjt_pkg::side_t  in_side,
	output logic             out_valid,
	output dhjt_pkg::lane_t  out_theta,
	output dhjt_pkg::lane_t  out_alpha,
	output dhjt_pkg::side_t  out_side
);
	import dhjt_pkg::*;

	localparam logic signed [32:0] ATAN = atan_q30(STAGE);

	logic  valid_q;
	lane_t theta_q, alpha_q;
	side_t side_q;

	function automatic lane_t rotate(input lane_t l);
		logic signed [31:0] xs;
		logic signed [31:0] ys;
		lane_t              r;
		xs = l.x >>> STAGE;
		ys = l.y >>> STAGE;
		r  = l;
		if (!l.z[32]) begin
			r.x = l.x - ys;
			r.y = l.y + xs;
			r.z = l.z - ATAN;
		end else begin
			r.x = l.x + ys;
			r.y = l.y - xs;
			r.z = l.z + ATAN;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		theta_q <= rotate(in_theta);
		alpha_q <= rotate(in_alpha);
		side_q  <= in_side;
	end

	assign out_valid = valid_q;
	assign out_theta = theta_q;
	assign out_alpha = alpha_q;
	assign out_side  = side_q;

endmodule

`default_nettype wire

FILE: src/dh_joint_transform.sv
// top level of the denavit-hartenberg joint transform, one joint per request
// path: done follows accept through the front end, the angle reduction pipe, the cordic cell row and the back end
// throughput: one request per clock, set by the cordic cell row advancing one stage a clock
// busy stays low, results cannot be held off by the receiver and are shown for one cycle
// reset clears every valid bit and loads the register defaults, results in flight are dropped
`default_nettype none

module dh_joint_transform #(
	parameter int unsigned CORDIC_STAGES = dhjt_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	// request side
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] joint_value,

	// register write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [31:0] cfg_data,

	// result side
	output logic                    done,
	output logic signed [31:0]      clamped_value,
	output logic signed [17:0]      rot_x_x,
	output logic signed [17:0]      rot_x_y,
	output logic signed [17:0]      rot_y_x,
	output logic signed [17:0]      rot_y_y,
	output logic signed [17:0]      rot_y_z,
	output logic signed [17:0]      rot_z_x,
	output logic signed [17:0]      rot_z_y,
	output logic signed [17:0]      rot_z_z,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z
);
	import dhjt_pkg::*;

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -35'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Q2.30 to Q16.16 with round half up, then limited to +-1.0
	function automatic logic signed [17:0] q30_to_q16(input logic signed [31:0] v);
		logic signed [32:0] sum;
		logic signed [32:0] sh;
		logic signed [17:0] r;
		sum = 33'(v) + 33'sd8192;
		sh  = sum >>> 14;
		if (sh > 33'sd65536) begin
			r = 18'sd65536;
		end else if (sh < -33'sd65536) begin
			r = -18'sd65536;
		end else begin
			r = sh[17:0];
		end
		return r;
	endfunction

	// Q16.16 product of two unit-range values, rounded
	function automatic logic signed [17:0] rnd_unit(input logic signed [35:0] p);
		logic signed [36:0] sum;
		logic signed [36:0] sh;
		sum = 37'(p) + 37'sd32768;
		sh  = sum >>> 16;
		return sh[17:0];
	endfunction

	// Q16.16 product of a length and a unit value, rounded and saturated
	function automatic logic signed [31:0] rnd_len(input logic signed [49:0] p);
		logic signed [50:0] sum;
		logic signed [50:0] sh;
		sum = 51'(p) + 51'sd32768;
		sh  = sum >>> 16;
		return sat32(sh[34:0]);
	endfunction

	// ------------------------------------------------------------------
	// configuration registers, always ready
	// ------------------------------------------------------------------

	logic        [1:0]  joint_type_q;
	logic signed [31:0] lower_limit_q;
	logic signed [31:0] upper_limit_q;
	logic signed [31:0] angle_offset_q;
	logic signed [31:0] distance_offset_q;
	logic signed [31:0] link_length_q;
	logic signed [31:0] twist_angle_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_type_q      <= JOINT_REVOLUTE;
			lower_limit_q     <= 32'sh80000000;
			upper_limit_q     <= 32'sh7fffffff;
			angle_offset_q    <= '0;
			distance_offset_q <= '0;
			link_length_q     <= '0;
			twist_angle_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_JOINT_TYPE:      joint_type_q      <= cfg_data[1:0];
				REG_LOWER_LIMIT:     lower_limit_q     <= $signed(cfg_data);
				REG_UPPER_LIMIT:     upper_limit_q     <= $signed(cfg_data);
				REG_ANGLE_OFFSET:    angle_offset_q    <= $signed(cfg_data);
				REG_DISTANCE_OFFSET: distance_offset_q <= $signed(cfg_data);
				REG_LINK_LENGTH:     link_length_q     <= $signed(cfg_data);
				REG_TWIST_ANGLE:     twist_angle_q     <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// front end: clamp, then form theta and d
	// ------------------------------------------------------------------

	logic               accept;
	logic               valid_s1, valid_s2;
	logic signed [31:0] clamped_s1, clamped_s2;
	logic signed [31:0] theta_s2, dist_s2;
	logic signed [32:0] theta_sum, dist_sum;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// crossed limits: the lower limit is checked first
	always_ff @(posedge clk) begin
		if (joint_value < lower_limit_q) begin
			clamped_s1 <= lower_limit_q;
		end else if (joint_value > upper_limit_q) begin
			clamped_s1 <= upper_limit_q;
		end else begin
			clamped_s1 <= joint_value;
		end
	end

	always_comb begin
		theta_sum = 33'(angle_offset_q) + 33'(clamped_s1);
		dist_sum  = 33'(distance_offset_q) + 33'(clamped_s1);
	end

	// a fixed joint, and the unused fourth type code, leave both offsets alone
	always_ff @(posedge clk) begin
		clamped_s2 <= clamped_s1;
		if (joint_type_q == JOINT_REVOLUTE) begin
			theta_s2 <= sat32(35'(theta_sum));
		end else begin
			theta_s2 <= angle_offset_q;
		end
		if (joint_type_q == JOINT_PRISMATIC) begin
			dist_s2 <= sat32(35'(dist_sum));
		end else begin
			dist_s2 <= distance_offset_q;
		end
	end

	// ------------------------------------------------------------------
	// angle reduction for theta and for the twist, payload delayed alongside
	// ------------------------------------------------------------------

	lane_t theta_red, alpha_red;
	side_t side_s2;
	logic  valid_dly_q [RED_LAT];
	side_t side_dly_q  [RED_LAT];

	assign side_s2.clamped = clamped_s2;
	assign side_s2.d_sum   = dist_s2;

	dhjt_reduce u_red_theta (
		.clk   (clk),
		.angle (theta_s2),
		.lane  (theta_red)
	);

	dhjt_reduce u_red_alpha (
		.clk   (clk),
		.angle (twist_angle_q),
		.lane  (alpha_red)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RED_LAT; i++) begin
				valid_dly_q[i] <= 1'b0;
			end
		end else begin
			valid_dly_q[0] <= valid_s2;
			for (int i = 1; i < RED_LAT; i++) begin
				valid_dly_q[i] <= valid_dly_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_dly_q[0] <= side_s2;
		for (int i = 1; i < RED_LAT; i++) begin
			side_dly_q[i] <= side_dly_q[i-1];
		end
	end

	// ------------------------------------------------------------------
	// cordic cell row, one micro-rotation per cell per clock
	// ------------------------------------------------------------------

	logic  valid_c [CORDIC_STAGES+1];
	lane_t theta_c [CORDIC_STAGES+1];
	lane_t alpha_c [CORDIC_STAGES+1];
	side_t side_c  [CORDIC_STAGES+1];

	assign valid_c[0] = valid_dly_q[RED_LAT-1];
	assign theta_c[0] = theta_red;
	assign alpha_c[0] = alpha_red;
	assign side_c[0]  = side_dly_q[RED_LAT-1];

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		dhjt_cordic_cell #(
			.STAGE (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[g]),
			.in_theta  (theta_c[g]),
			.in_alpha  (alpha_c[g]),
			.in_side   (side_c[g]),
			.out_valid (valid_c[g+1]),
			.out_theta (theta_c[g+1]),
			.out_alpha (alpha_c[g+1]),
			.out_side  (side_c[g+1])
		);
	end

	// ------------------------------------------------------------------
	// back end: round sine and cosine, form products, round and saturate
	// ------------------------------------------------------------------

	lane_t th_end, al_end;
	side_t sd_end;

	assign th_end = theta_c[CORDIC_STAGES];
	assign al_end = alpha_c[CORDIC_STAGES];
	assign sd_end = side_c[CORDIC_STAGES];

	logic               valid_s3, valid_s4;
	logic signed [17:0] ct_s3, st_s3, ca_s3, sa_s3;
	logic signed [17:0] ct_s4, st_s4, ca_s4, sa_s4;
	logic signed [17:0] ct_r, st_r, ca_r, sa_r;
	side_t              side_s3, side_s4;
	logic signed [35:0] stca_s4, ctca_s4, stsa_s4, ctsa_s4;
	logic signed [49:0] act_s4, ast_s4;

	always_comb begin
		ct_r = q30_to_q16(th_end.x);
		st_r = q30_to_q16(th_end.y);
		ca_r = q30_to_q16(al_end.x);
		sa_r = q30_to_q16(al_end.y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_c[CORDIC_STAGES];
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		// undo the quadrant fold
		ct_s3   <= th_end.neg ? -ct_r : ct_r;
		st_s3   <= th_end.neg ? -st_r : st_r;
		ca_s3   <= al_end.neg ? -ca_r : ca_r;
		sa_s3   <= al_end.neg ? -sa_r : sa_r;
		side_s3 <= sd_end;

		stca_s4 <= st_s3 * ca_s3;
		ctca_s4 <= ct_s3 * ca_s3;
		stsa_s4 <= st_s3 * sa_s3;
		ctsa_s4 <= ct_s3 * sa_s3;
		act_s4  <= link_length_q * ct_s3;
		ast_s4  <= link_length_q * st_s3;
		ct_s4   <= ct_s3;
		st_s4   <= st_s3;
		ca_s4   <= ca_s3;
		sa_s4   <= sa_s3;
		side_s4 <= side_s3;
	end

	// result registers
	logic               done_q;
	logic signed [31:0] clamped_q, pos_x_q, pos_y_q, pos_z_q;
	logic signed [17:0] rxx_q, rxy_q, ryx_q, ryy_q, ryz_q, rzx_q, rzy_q, rzz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		clamped_q <= side_s4.clamped;
		rxx_q     <= ct_s4;
		rxy_q     <= st_s4;
		ryx_q     <= -rnd_unit(stca_s4);
		ryy_q     <= rnd_unit(ctca_s4);
		ryz_q     <= sa_s4;
		rzx_q     <= rnd_unit(stsa_s4);
		rzy_q     <= -rnd_unit(ctsa_s4);
		rzz_q     <= ca_s4;
		pos_x_q   <= rnd_len(act_s4);
		pos_y_q   <= rnd_len(ast_s4);
		pos_z_q   <= side_s4.d_sum;
	end

	assign done          = done_q;
	assign clamped_value = clamped_q;
	assign rot_x_x       = rxx_q;
	assign rot_x_y       = rxy_q;
	assign rot_y_x       = ryx_q;
	assign rot_y_y       = ryy_q;
	assign rot_y_z       = ryz_q;
	assign rot_z_x       = rzx_q;
	assign rot_z_y       = rzy_q;
	assign rot_z_z       = rzz_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;
	assign pos_z         = pos_z_q;

endmodule

`default_nettype wire

FILE: src/dhjt_checker.sv
// port-level checks of the joint transform and their bind to the top level
`default_nettype none

`include "dh_joint_transform_defines.svh"

module dhjt_checker #(
	parameter int unsigned CORDIC_STAGES = dhjt_pkg::CORDIC_STAGES_DEF
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               cfg_valid,
	input wire logic               cfg_ready,
	input wire logic               done,
	input wire logic signed [17:0] rot_x_x,
	input wire logic signed [17:0] rot_y_y,
	input wire logic signed [17:0] rot_z_z
);
	import dhjt_pkg::*;

	localparam int unsigned LAT = CORDIC_STAGES + FIXED_LAT;

	// every request yields exactly one strobe after the pipeline depth
	`DHJT_ASSERT_DELAY(a_req_to_done, clk, arst_n, start && !busy, LAT, done, "request lost")
	`DHJT_ASSERT_IMPLY(a_done_has_req, clk, arst_n, done, $past(start && !busy, LAT), "spurious result")
	// the diagonal rotation entries stay within unit range
	`DHJT_ASSERT_IMPLY(a_rot_range, clk, arst_n, done, (rot_x_x <= 18'sd65536) && (rot_x_x >= -18'sd65536) && (rot_y_y <= 18'sd65536) && (rot_y_y >= -18'sd65536) && (rot_z_z <= 18'sd65536) && (rot_z_z >= -18'sd65536), "rotation out of range")
	`DHJT_ASSERT_IMPLY(a_cfg_taken, clk, arst_n, cfg_valid, cfg_ready, "register write stalled")

endmodule

bind dh_joint_transform dhjt_checker #(
	.CORDIC_STAGES (CORDIC_STAGES)
) u_dhjt_checker (.*);

`default_nettype wire

FILE: test/dh_joint_transform_test.sv
// self-checking testbench of the joint transform: a directed table, then random register settings
module dh_joint_transform_test;

	import dhjt_pkg::cfg_reg_t;
	import dhjt_pkg::joint_type_t;
	import dhjt_pkg::REG_JOINT_TYPE;
	import dhjt_pkg::REG_LOWER_LIMIT;
	import dhjt_pkg::REG_UPPER_LIMIT;
	import dhjt_pkg::REG_ANGLE_OFFSET;
	import dhjt_pkg::REG_DISTANCE_OFFSET;
	import dhjt_pkg::REG_LINK_LENGTH;
	import dhjt_pkg::REG_TWIST_ANGLE;
	import dhjt_pkg::JOINT_REVOLUTE;
	import dhjt_pkg::JOINT_PRISMATIC;
	import dhjt_pkg::JOINT_FIXED;

	// rotation stages of the instance, and request-to-result latency that follows from it
	localparam int ROT_STAGES = 16;
	localparam int LATENCY    = ROT_STAGES + 12;
	// cycles without any handshake or result before the run is abandoned
	localparam int STALL_LIMIT = 2000;

	// register index with no register behind it, writes there must change nothing
	localparam logic [2:0] REG_SPARE = 3'd7;

	// angle constants in Q16.16
	localparam longint FULL_TURN = 411775;
	localparam longint HALF_TURN = 205887;
	localparam longint QUARTER_TURN = 102944;
	// start vector of the rotation, gain-compensated, Q2.30
	localparam longint ROT_GAIN = 652032874;

	// arctangent of 2^-i, Q2.30
	localparam longint ARCTAN_Q30 [0:29] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
		128, 64, 32, 16, 8, 4, 2
	};

	// random part: settings phases and requests per phase, the last phase has no request gaps
	localparam int PHASES = 13;
	localparam int PHASE_REQUESTS = 110;

	// one result: the clamped joint value and the transform entries
	typedef struct {
		logic signed [31:0] clamped_value;
		logic signed [17:0] rot_x_x;
		logic signed [17:0] rot_x_y;
		logic signed [17:0] rot_y_x;
		logic signed [17:0] rot_y_y;
		logic signed [17:0] rot_y_z;
		logic signed [17:0] rot_z_x;
		logic signed [17:0] rot_z_y;
		logic signed [17:0] rot_z_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} joint_frame_t;

	// directed table rows: a register write, a request checked by prediction,
	// or a request whose clamped value and position are known outright
	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_PREDICT,
		ROW_KNOWN
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [31:0] data;
		logic [31:0] clamp;
		logic [31:0] pos_d;
	} stim_row_t;

	// known rows only appear while the link length is still zero, so pos_x and pos_y are zero
	localparam int DIRECTED_ROWS = 39;
	localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		// reset settings: revolute, open limits, zero offsets
		'{ROW_KNOWN,   REG_JOINT_TYPE,      32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
		'{ROW_KNOWN,   REG_JOINT_TYPE,      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000},
		'{ROW_KNOWN,   REG_JOINT_TYPE,      32'h8000_0000, 32'h8000_0000, 32'h0000_0000},
		// quadrant fold edges and a full turn
		'{ROW_PREDICT, REG_JOINT_TYPE,      32'sd102944,   32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      32'sd102945,   32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      -32'sd102945,  32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      32'sd205888,   32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      -32'sd205887,  32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      32'sd411775,   32'h0,         32'h0},
		// angle sum saturates high, then low
		'{ROW_WRITE,   REG_ANGLE_OFFSET,    32'h7FFF_FFFF, 32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      32'h0000_0001, 32'h0,         32'h0},
		'{ROW_WRITE,   REG_ANGLE_OFFSET,    32'h8000_0000, 32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      32'h8000_0000, 32'h0,         32'h0},
		// prismatic: distance sum saturates
		'{ROW_WRITE,   REG_JOINT_TYPE,      32'h0000_0001, 32'h0,         32'h0},
		'{ROW_WRITE,   REG_DISTANCE_OFFSET, 32'h7FFF_FFFF, 32'h0,         32'h0},
		'{ROW_KNOWN,   REG_JOINT_TYPE,      32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF},
		'{ROW_KNOWN,   REG_JOINT_TYPE,      32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF},
		'{ROW_WRITE,   REG_DISTANCE_OFFSET, 32'h8000_0000, 32'h0,         32'h0},
		'{ROW_KNOWN,   REG_JOINT_TYPE,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000},
		// crossed limits on a fixed joint
		'{ROW_WRITE,   REG_LOWER_LIMIT,     32'sd65536,    32'h0,         32'h0},
		'{ROW_WRITE,   REG_UPPER_LIMIT,     -32'sd65536,   32'h0,         32'h0},
		'{ROW_WRITE,   REG_JOINT_TYPE,      32'(JOINT_FIXED), 32'h0,      32'h0},
		'{ROW_KNOWN,   REG_JOINT_TYPE,      -32'sd131072,  32'sd65536,    32'h8000_0000},
		'{ROW_KNOWN,   REG_JOINT_TYPE,      32'sd131072,   -32'sd65536,   32'h8000_0000},
		'{ROW_KNOWN,   REG_JOINT_TYPE,      32'h0000_0000, 32'sd65536,    32'h8000_0000},
		// type code 3 behaves as fixed, upper data bits set too
		'{ROW_WRITE,   REG_JOINT_TYPE,      32'hFFFF_FFFF, 32'h0,         32'h0},
		'{ROW_KNOWN,   REG_JOINT_TYPE,      32'h0000_0005, 32'sd65536,    32'h8000_0000},
		// write to the unused index is dropped
		'{ROW_WRITE,   REG_SPARE,           32'h5A5A_A5A5, 32'h0,         32'h0},
		// extreme link and twist
		'{ROW_WRITE,   REG_LOWER_LIMIT,     32'h8000_0000, 32'h0,         32'h0},
		'{ROW_WRITE,   REG_UPPER_LIMIT,     32'h7FFF_FFFF, 32'h0,         32'h0},
		'{ROW_WRITE,   REG_LINK_LENGTH,     32'h7FFF_FFFF, 32'h0,         32'h0},
		'{ROW_WRITE,   REG_TWIST_ANGLE,     32'sd102944,   32'h0,         32'h0},
		'{ROW_WRITE,   REG_JOINT_TYPE,      32'(JOINT_REVOLUTE), 32'h0,   32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      32'h0000_0000, 32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      32'sd205887,   32'h0,         32'h0},
		'{ROW_WRITE,   REG_LINK_LENGTH,     32'h8000_0000, 32'h0,         32'h0},
		'{ROW_WRITE,   REG_TWIST_ANGLE,     -32'sd205888,  32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      -32'sd102944,  32'h0,         32'h0},
		'{ROW_PREDICT, REG_JOINT_TYPE,      32'h7FFF_FFFF, 32'h0,         32'h0}
	};

	logic clk = 1'b0;
	logic arst_n;

	logic               start;
	logic               busy;
	logic signed [31:0] joint_value;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               done;
	logic signed [31:0] clamped_value;
	logic signed [17:0] rot_x_x;
	logic signed [17:0] rot_x_y;
	logic signed [17:0] rot_y_x;
	logic signed [17:0] rot_y_y;
	logic signed [17:0] rot_y_z;
	logic signed [17:0] rot_z_x;
	logic signed [17:0] rot_z_y;
	logic signed [17:0] rot_z_z;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	// predictor copy of the registers
	logic [1:0] jt_kind;
	int         lim_lo;
	int         lim_hi;
	int         theta_ofs;
	int         d_ofs;
	int         link_a;
	int         alpha;

	// frames of accepted requests, oldest first
	joint_frame_t pending_frames[$];

	int mismatches;
	int requests_sent;
	int frames_checked;
	int settings_applied;
	int stall_cycles;

	dh_joint_transform #(
		.CORDIC_STAGES(ROT_STAGES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.joint_value  (joint_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.clamped_value(clamped_value),
		.rot_x_x      (rot_x_x),
		.rot_x_y      (rot_x_y),
		.rot_y_x      (rot_y_x),
		.rot_y_y      (rot_y_y),
		.rot_y_z      (rot_y_z),
		.rot_z_x      (rot_z_x),
		.rot_z_y      (rot_z_y),
		.rot_z_z      (rot_z_z),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	function automatic longint clip_word(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Q2.30 rotation output to Q16.16, round half up, limited to one
	function automatic longint cordic_to_q16(input longint v);
		longint r;
		r = (v + 8192) >>> 14;
		if (r > 65536)
			r = 65536;
		if (r < -65536)
			r = -65536;
		return r;
	endfunction

	// Q16.16 product, round half up
	function automatic longint fix_mul(input longint a, input longint b);
		return (a * b + 32768) >>> 16;
	endfunction

	// sine and cosine of a Q16.16 angle
	function automatic void unit_rotation(input longint ang, output longint s, output longint c);
		longint r;
		longint x;
		longint y;
		longint z;
		longint nx;
		bit     flip;
		r = ang % FULL_TURN;
		flip = 1'b0;
		x = ROT_GAIN;
		y = 0;
		// fold into (-pi, pi], then into [-pi/2, pi/2] with a sign flip
		if (r < 0)
			r += FULL_TURN;
		if (r > HALF_TURN)
			r -= FULL_TURN;
		if (r > QUARTER_TURN) begin
			r -= HALF_TURN;
			flip = 1'b1;
		end else if (r < -QUARTER_TURN) begin
			r += HALF_TURN;
			flip = 1'b1;
		end
		z = r * 16384;
		for (int i = 0; i < ROT_STAGES && i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARCTAN_Q30[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARCTAN_Q30[i];
			end
			x = nx;
		end
		c = cordic_to_q16(x);
		s = cordic_to_q16(y);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	// frame for one joint value under the current register copy
	function automatic joint_frame_t predict_frame(input int v);
		joint_frame_t f;
		longint val;
		longint theta;
		longint d_total;
		longint st;
		longint ct;
		longint sa;
		longint ca;
		val = v;
		// lower bound wins when the limits are crossed
		if (val < lim_lo)
			val = lim_lo;
		else if (val > lim_hi)
			val = lim_hi;
		theta = theta_ofs;
		d_total = d_ofs;
		// fixed and the spare type code leave both offsets alone
		if (jt_kind == JOINT_REVOLUTE)
			theta = clip_word(theta + val);
		else if (jt_kind == JOINT_PRISMATIC)
			d_total = clip_word(d_total + val);
		unit_rotation(theta, st, ct);
		unit_rotation(alpha, sa, ca);
		f.clamped_value = 32'(val);
		f.rot_x_x = 18'(ct);
		f.rot_x_y = 18'(st);
		f.rot_y_x = 18'(-fix_mul(st, ca));
		f.rot_y_y = 18'(fix_mul(ct, ca));
		f.rot_y_z = 18'(sa);
		f.rot_z_x = 18'(fix_mul(st, sa));
		f.rot_z_y = 18'(-fix_mul(ct, sa));
		f.rot_z_z = 18'(ca);
		f.pos_x = 32'(clip_word(fix_mul(link_a, ct)));
		f.pos_y = 32'(clip_word(fix_mul(link_a, st)));
		f.pos_z = 32'(d_total);
		return f;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// Q16.16 value biased toward extremes, angle folds and small angles
	function automatic int pick_q16();
		int b;
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return int'($urandom);
			4, 5, 6: return int'($urandom_range(0, 1647100)) - 823550;
			7: begin
				// just around a quarter, half or full turn
				case ($urandom_range(0, 2))
					0: b = int'(QUARTER_TURN);
					1: b = int'(HALF_TURN);
					default: b = int'(FULL_TURN);
				endcase
				if ($urandom_range(0, 1) == 1)
					b = -b;
				return b + int'($urandom_range(0, 4)) - 2;
			end
			8: return int'($urandom_range(0, 4)) - 2;
			default: return int'($urandom_range(0, 262143)) - 131072;
		endcase
	endfunction

	// every request waits here until the block takes it, start stays high on return
	task automatic send_joint(input int v, input joint_frame_t f);
		start <= 1'b1;
		joint_value <= v;
		do
			@(posedge clk);
		while (busy);
		pending_frames.push_back(f);
		requests_sent++;
		@(negedge clk);
	endtask

	// register write, cfg_valid stays high on return so back-to-back writes keep it up
	task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_JOINT_TYPE: jt_kind = data[1:0];
			REG_LOWER_LIMIT: lim_lo = data;
			REG_UPPER_LIMIT: lim_hi = data;
			REG_ANGLE_OFFSET: theta_ofs = data;
			REG_DISTANCE_OFFSET: d_ofs = data;
			REG_LINK_LENGTH: link_a = data;
			REG_TWIST_ANGLE: alpha = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// stop requests and wait until every frame in flight has come back
	task automatic drain_frames();
		start <= 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
	endtask

	// one random setting of all registers, then a run of requests under it
	task automatic run_phase(input bit with_gaps);
		int a;
		int b;
		int lo;
		int hi;
		int data;
		int v;
		drain_frames();
		// limits: open, ordered, crossed or a narrow window
		a = pick_q16();
		b = pick_q16();
		case ($urandom_range(0, 3))
			0: begin
				lo = 32'sh8000_0000;
				hi = 32'sh7FFF_FFFF;
			end
			1: begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
			2: begin
				lo = (a < b) ? b : a;
				hi = (a < b) ? a : b;
			end
			default: begin
				lo = -int'($urandom_range(0, 200000));
				hi = int'($urandom_range(0, 200000));
			end
		endcase
		for (int r = 0; r <= 7; r++) begin
			// gaps on the write channel now and then
			if ($urandom_range(0, 3) == 0) begin
				cfg_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			case (r)
				REG_JOINT_TYPE: begin
					data = int'($urandom);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: data[1:0] = JOINT_REVOLUTE;
						4, 5, 6, 7: data[1:0] = JOINT_PRISMATIC;
						8: data[1:0] = JOINT_FIXED;
						default: data[1:0] = 2'd3;
					endcase
				end
				REG_LOWER_LIMIT: data = lo;
				REG_UPPER_LIMIT: data = hi;
				REG_SPARE: data = int'($urandom);
				default: data = pick_q16();
			endcase
			// the spare index is only hit in some phases
			if (r != REG_SPARE || $urandom_range(0, 2) == 0)
				write_register(3'(r), data);
		end
		cfg_valid <= 1'b0;
		settings_applied++;
		for (int n = 0; n < PHASE_REQUESTS; n++) begin
			if (with_gaps && $urandom_range(0, 4) == 0) begin
				start <= 1'b0;
				joint_value <= $urandom;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			// values around the limits as well as the general mix
			case ($urandom_range(0, 5))
				0: v = lim_lo + int'($urandom_range(0, 4)) - 2;
				1: v = lim_hi + int'($urandom_range(0, 4)) - 2;
				default: v = pick_q16();
			endcase
			send_joint(v, predict_frame(v));
		end
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// ---------------------------------------------------------------- result check

	// each done strobe is compared with the oldest pending frame
	always @(posedge clk) begin : frame_check
		joint_frame_t want;
		if (arst_n && done) begin
			if (pending_frames.size() == 0) begin
				$error("result strobe with no request pending");
				mismatches++;
			end else begin
				want = pending_frames.pop_front();
				check_field("clamped_value", want.clamped_value, clamped_value);
				check_field("rot_x_x", want.rot_x_x, rot_x_x);
				check_field("rot_x_y", want.rot_x_y, rot_x_y);
				check_field("rot_y_x", want.rot_y_x, rot_y_x);
				check_field("rot_y_y", want.rot_y_y, rot_y_y);
				check_field("rot_y_z", want.rot_y_z, rot_y_z);
				check_field("rot_z_x", want.rot_z_x, rot_z_x);
				check_field("rot_z_y", want.rot_z_y, rot_z_y);
				check_field("rot_z_z", want.rot_z_z, rot_z_z);
				check_field("pos_x", want.pos_x, pos_x);
				check_field("pos_y", want.pos_y, pos_y);
				check_field("pos_z", want.pos_z, pos_z);
				frames_checked++;
			end
		end
	end

	// watchdog: any request, register write or result restarts the count
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin : main_sequence
		stim_row_t    row;
		joint_frame_t f;
		// every input known from time zero
		arst_n = 1'b0;
		start = 1'b0;
		joint_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_JOINT_TYPE;
		cfg_data = '0;
		mismatches = 0;
		requests_sent = 0;
		frames_checked = 0;
		settings_applied = 0;
		stall_cycles = 0;
		// register defaults after reset
		jt_kind = JOINT_REVOLUTE;
		lim_lo = 32'sh8000_0000;
		lim_hi = 32'sh7FFF_FFFF;
		theta_ofs = 0;
		d_ofs = 0;
		link_a = 0;
		alpha = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, register writes only once the pipe is empty
		for (int n = 0; n < DIRECTED_ROWS; n++) begin
			row = DIRECTED[n];
			if (row.kind == ROW_WRITE) begin
				drain_frames();
				write_register(row.idx, row.data);
			end else begin
				cfg_valid <= 1'b0;
				f = predict_frame(row.data);
				// clamped value and position typed in, rotation entries still predicted
				if (row.kind == ROW_KNOWN) begin
					f.clamped_value = row.clamp;
					f.pos_x = '0;
					f.pos_y = '0;
					f.pos_z = row.pos_d;
				end
				send_joint(row.data, f);
			end
		end
		settings_applied++;

		// random settings, gaps on the request side except in the last phase
		for (int p = 0; p < PHASES; p++)
			run_phase(p != PHASES - 1);

		// let the pipe empty, then watch for stray results
		drain_frames();
		repeat (LATENCY + 8) @(posedge clk);

		$display("checked %0d results of %0d requests under %0d register settings",
			frames_checked, requests_sent, settings_applied);
		$display("settings mixed revolute, prismatic and fixed joints, crossed limits and extremes");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: dh_joint_transform.f
+incdir+src
src/dhjt_pkg.sv
src/dhjt_reduce.sv
src/dhjt_cordic_cell.sv
src/dh_joint_transform.sv
src/dhjt_checker.sv
test/dh_joint_transform_test.sv
